### hdl/uwd_pkg.sv
package uwd_pkg;

  // image geometry
  localparam int SIDE_MAX = 64;
  localparam int POS_W    = $clog2(SIDE_MAX);
  localparam int REG_W    = 7;
  localparam int PIX_W    = 8;
  localparam int RUN_W    = 7;
  localparam int COUNT_W  = 13;

  localparam logic [REG_W-1:0]   SIDE_LIMIT = REG_W'(SIDE_MAX);
  localparam logic [RUN_W-1:0]   RUN_MAX    = {RUN_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

  // register map
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_SIDE    = 2'd0,
    REG_WINDOW_HEIGHT = 2'd1,
    REG_WINDOW_WIDTH  = 2'd2,
    REG_UNUSED        = 2'd3
  } cfg_reg_t;

  // per-column history kept in the column store
  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [RUN_W-1:0] run;
  } col_entry_t;

  localparam int COL_ENTRY_W = $bits(col_entry_t);

endpackage

### hdl/uwd_ram.sv
module uwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/uniform_window_detector_top.sv
// Uniform window detector: takes a square image as a raster stream of 8-bit pixels and,
// for each pixel, returns one word telling whether that pixel closes a window of the
// configured height and width inside the image, whether that window holds a single value,
// its top-left anchor, the running count of uniform windows in the frame, and (on tlast)
// the last pixel of the frame. One pixel is taken per clock while the result stream is not
// stalled; each pixel is registered in the work stage together with the registered read of
// the per-column history memory, and its result in the result register. Any write to a used
// register restarts the frame; write registers only while no pixel is in flight.
module uniform_window_detector_top (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pixel
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [5:0] anchor_row, [11:6] anchor_col, [24:12] match_total
  output logic [1:0]  m_tuser,   // [0] window_done, [1] is_uniform
  output logic        m_tlast,   // frame_end
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  // configuration registers
  logic [uwd_pkg::REG_W-1:0] image_side;
  logic [uwd_pkg::REG_W-1:0] window_height;
  logic [uwd_pkg::REG_W-1:0] window_width;
  logic                      cfg_write;
  logic                      cfg_hit;

  // raster position and row state
  logic [uwd_pkg::POS_W-1:0]   row_pos;
  logic [uwd_pkg::POS_W-1:0]   col_pos;
  logic [uwd_pkg::RUN_W-1:0]   row_run;
  logic [uwd_pkg::PIX_W-1:0]   previous_pixel;
  logic [uwd_pkg::COUNT_W-1:0] found_count;

  // effective geometry
  logic [uwd_pkg::REG_W-1:0] side_eff;
  logic [uwd_pkg::REG_W-1:0] side_min1;
  logic [uwd_pkg::REG_W-1:0] h_eff;
  logic [uwd_pkg::REG_W-1:0] w_eff;

  // accept side
  logic                      accept;
  logic [uwd_pkg::POS_W-1:0] cur_row;
  logic [uwd_pkg::POS_W-1:0] cur_col;
  logic [uwd_pkg::REG_W-1:0] cur_row_inc;
  logic [uwd_pkg::REG_W-1:0] cur_col_inc;

  // work stage
  logic                      s1_valid;
  logic [uwd_pkg::PIX_W-1:0] s1_pix;
  logic [uwd_pkg::POS_W-1:0] s1_row;
  logic [uwd_pkg::POS_W-1:0] s1_col;
  logic                      advance;

  // column store and bypass
  uwd_pkg::col_entry_t ram_rd;
  uwd_pkg::col_entry_t col_rd;
  uwd_pkg::col_entry_t col_wr;
  uwd_pkg::col_entry_t byp_data;
  logic                byp_hit;

  // per-word results
  logic [uwd_pkg::REG_W-1:0]   r_inc;
  logic [uwd_pkg::REG_W-1:0]   c_inc;
  logic [uwd_pkg::RUN_W-1:0]   crun;
  logic [uwd_pkg::RUN_W-1:0]   rr;
  logic                        done;
  logic                        uni;
  logic                        fend;
  logic [uwd_pkg::REG_W-1:0]   anchor_r;
  logic [uwd_pkg::REG_W-1:0]   anchor_c;
  logic [uwd_pkg::COUNT_W-1:0] found_next;

  // config port
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_write && (uwd_pkg::cfg_reg_t'(cfg_index) != uwd_pkg::REG_UNUSED);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_side    <= uwd_pkg::REG_W'(6);
      window_height <= uwd_pkg::REG_W'(3);
      window_width  <= uwd_pkg::REG_W'(2);
    end else if (cfg_write) begin
      case (uwd_pkg::cfg_reg_t'(cfg_index))
        uwd_pkg::REG_IMAGE_SIDE:    image_side    <= cfg_data;
        uwd_pkg::REG_WINDOW_HEIGHT: window_height <= cfg_data;
        uwd_pkg::REG_WINDOW_WIDTH:  window_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero means one, side clamps to the store depth
  always_comb begin
    side_min1 = (image_side == '0) ? uwd_pkg::REG_W'(1) : image_side;
    side_eff  = (side_min1 > uwd_pkg::SIDE_LIMIT) ? uwd_pkg::SIDE_LIMIT : side_min1;
    h_eff     = (window_height == '0) ? uwd_pkg::REG_W'(1) : window_height;
    w_eff     = (window_width == '0) ? uwd_pkg::REG_W'(1) : window_width;
  end

  // handshake
  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;

  // position of the incoming word
  always_comb begin
    cur_row     = ({1'b0, row_pos} >= side_eff) ? '0 : row_pos;
    cur_col     = ({1'b0, col_pos} >= side_eff) ? '0 : col_pos;
    cur_row_inc = {1'b0, cur_row} + uwd_pkg::REG_W'(1);
    cur_col_inc = {1'b0, cur_col} + uwd_pkg::REG_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (cfg_hit) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      if (cur_col_inc >= side_eff) begin
        col_pos <= '0;
        row_pos <= (cur_row_inc >= side_eff) ? '0 : cur_row_inc[uwd_pkg::POS_W-1:0];
      end else begin
        col_pos <= cur_col_inc[uwd_pkg::POS_W-1:0];
      end
    end
  end

  // work stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= s_tdata;
      s1_row   <= cur_row;
      s1_col   <= cur_col;
      // the word leaving now may write the column being read
      byp_hit  <= advance && (s1_col == cur_col);
      byp_data <= col_wr;
    end
  end

  uwd_ram #(
    .WIDTH(uwd_pkg::COL_ENTRY_W),
    .DEPTH(uwd_pkg::SIDE_MAX)
  ) u_col_ram (
    .clk    (clk),
    .wr_en  (advance),
    .wr_addr(s1_col),
    .wr_data(col_wr),
    .rd_en  (accept),
    .rd_addr(cur_col),
    .rd_data(ram_rd)
  );

  assign col_rd = byp_hit ? byp_data : ram_rd;

  // column run, row run and window test
  always_comb begin
    r_inc = {1'b0, s1_row} + uwd_pkg::REG_W'(1);
    c_inc = {1'b0, s1_col} + uwd_pkg::REG_W'(1);

    if (s1_row == '0 || col_rd.value != s1_pix) begin
      crun = uwd_pkg::RUN_W'(1);
    end else begin
      crun = (col_rd.run == uwd_pkg::RUN_MAX) ? uwd_pkg::RUN_MAX : col_rd.run + 1'b1;
    end
    col_wr.value = s1_pix;
    col_wr.run   = crun;

    if (crun < h_eff) begin
      rr = '0;
    end else if (s1_col == '0 || row_run == '0 || previous_pixel != s1_pix) begin
      rr = uwd_pkg::RUN_W'(1);
    end else begin
      rr = (row_run == uwd_pkg::RUN_MAX) ? uwd_pkg::RUN_MAX : row_run + 1'b1;
    end

    done     = (r_inc >= h_eff) && (c_inc >= w_eff);
    uni      = done && (rr >= w_eff);
    fend     = (r_inc == side_eff) && (c_inc == side_eff);
    anchor_r = r_inc - h_eff;
    anchor_c = c_inc - w_eff;
    found_next = (uni && found_count != uwd_pkg::COUNT_MAX) ? found_count + 1'b1
                                                             : found_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_run        <= '0;
      previous_pixel <= '0;
      found_count    <= '0;
    end else if (cfg_hit) begin
      row_run     <= '0;
      found_count <= '0;
    end else if (advance) begin
      row_run        <= rr;
      previous_pixel <= s1_pix;
      found_count    <= fend ? '0 : found_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tuser <= {uni, done};
      m_tlast <= fend;
      m_tdata <= {7'd0,
                  found_next,
                  done ? anchor_c[uwd_pkg::POS_W-1:0] : uwd_pkg::POS_W'(0),
                  done ? anchor_r[uwd_pkg::POS_W-1:0] : uwd_pkg::POS_W'(0)};
    end
  end

  // checks
  a_uni_needs_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0])
    else $error("uniform flag without a completed window");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_col) && $stable(s1_pix))
    else $error("work stage lost a stalled word");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    found_count != $past(found_count) |->
      found_count == $past(found_count) + 1'b1 || found_count == '0)
    else $error("match count moved by more than one");

  a_no_write_unless_advance: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !advance && s_tready)
    else $error("empty work stage not ready");

endmodule
